FILE: sv/stl_pkg.sv
// Shared widths, token kinds, character codes and queue item types for the lexer.
package stl_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int LINE_BITS_DEF   = 24;
    localparam int COLUMN_BITS_DEF = 16;

    localparam int CHAR_W = 8;
    localparam int KIND_W = 4;
    localparam int OFF_W  = 32;
    localparam int LEN_W  = 16;
    localparam int LINE_W = 24;
    localparam int COL_W  = 16;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [KIND_W-1:0] {
        K_IDENT   = 4'd0,
        K_NUMBER  = 4'd1,
        K_ADD     = 4'd2,
        K_MUL     = 4'd3,
        K_ARROW   = 4'd4,
        K_COLON   = 4'd5,
        K_COMMA   = 4'd6,
        K_PERIOD  = 4'd7,
        K_LBRACE  = 4'd8,
        K_RBRACE  = 4'd9,
        K_LPAREN  = 4'd10,
        K_RPAREN  = 4'd11,
        K_EOL     = 4'd12,
        K_EOF     = 4'd13,
        K_INVALID = 4'd14
    } t_kind;

    localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL         = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HASH       = 8'h23;
    localparam logic [CHAR_W-1:0] CH_LPAREN     = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN     = 8'h29;
    localparam logic [CHAR_W-1:0] CH_STAR       = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS       = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_COMMA      = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT        = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SLASH      = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON      = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_GT         = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_LBRACE     = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE     = 8'h7D;

    typedef struct packed {
        logic  digit;
        logic  word;
        logic  blank;
        logic  hash;
        logic  newline;
        logic  dot;
        logic  symbol;
        t_kind sym_kind;
    } t_class;

    typedef struct packed {
        logic [CHAR_W-1:0] char_byte;
        logic              end_of_input;
        t_class            cls;
    } t_item;

endpackage

FILE: sv/source_text_lexer.sv
// Source text lexer top level: front classifier, item queue and scanner back end.
// Accepted bytes pass through the item queue and the back end into the output register.
// Throughput: one byte per cycle while each byte yields at most one token and the output is
// not stalled; a byte with more tokens holds the back end until each passes the output register.
// Reset: synchronous, active low; clears the queue, scanner mode and output valid,
// sets offset to 0 and line and column to 1.
module source_text_lexer
    import stl_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CHAR_W-1:0] i_char_byte,
    input  logic              i_end_of_input,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_token_kind,
    output logic [CHAR_W-1:0] o_first_char,
    output logic [OFF_W-1:0]  o_start_offset,
    output logic [LEN_W-1:0]  o_token_length,
    output logic [LINE_W-1:0] o_line_number,
    output logic [COL_W-1:0]  o_column_number,
    output logic              o_last_of_run
);

    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;
    t_item w_push_item;
    t_item w_head_item;

    stl_front u_front (
        .i_valid        (i_valid),
        .i_char_byte    (i_char_byte),
        .i_end_of_input (i_end_of_input),
        .i_full         (w_full),
        .o_stall        (o_stall),
        .o_push         (w_push),
        .o_item         (w_push_item)
    );

    stl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    stl_back #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (w_head_item),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_token_kind    (o_token_kind),
        .o_first_char    (o_first_char),
        .o_start_offset  (o_start_offset),
        .o_token_length  (o_token_length),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

FILE: sv/stl_front.sv
// Input side: accepts source bytes, classifies them and pushes them into the queue.
module stl_front
    import stl_pkg::*;
(
    input  logic              i_valid,
    input  logic [CHAR_W-1:0] i_char_byte,
    input  logic              i_end_of_input,
    input  logic              i_full,
    output logic              o_stall,
    output logic              o_push,
    output t_item             o_item
);

    t_class w_cls;
    logic   w_alpha;

    always_comb begin
        w_alpha = ((i_char_byte >= CH_LOWER_A) && (i_char_byte <= CH_LOWER_Z)) ||
                  ((i_char_byte >= CH_UPPER_A) && (i_char_byte <= CH_UPPER_Z));
        w_cls.digit   = (i_char_byte >= CH_DIGIT_0) && (i_char_byte <= CH_DIGIT_9);
        w_cls.word    = w_alpha || w_cls.digit || (i_char_byte == CH_UNDERSCORE);
        w_cls.blank   = (i_char_byte == CH_SPACE) || (i_char_byte == CH_TAB) ||
                        (i_char_byte == CH_CR);
        w_cls.hash    = (i_char_byte == CH_HASH);
        w_cls.newline = (i_char_byte == CH_NL);
        w_cls.dot     = (i_char_byte == CH_DOT);
        w_cls.symbol  = 1'b1;
        case (i_char_byte)
            CH_PLUS, CH_MINUS: begin
                w_cls.sym_kind = K_ADD;
            end
            CH_STAR, CH_SLASH: begin
                w_cls.sym_kind = K_MUL;
            end
            CH_GT: begin
                w_cls.sym_kind = K_ARROW;
            end
            CH_COLON: begin
                w_cls.sym_kind = K_COLON;
            end
            CH_COMMA: begin
                w_cls.sym_kind = K_COMMA;
            end
            CH_DOT: begin
                w_cls.sym_kind = K_PERIOD;
            end
            CH_LBRACE: begin
                w_cls.sym_kind = K_LBRACE;
            end
            CH_RBRACE: begin
                w_cls.sym_kind = K_RBRACE;
            end
            CH_LPAREN: begin
                w_cls.sym_kind = K_LPAREN;
            end
            CH_RPAREN: begin
                w_cls.sym_kind = K_RPAREN;
            end
            default: begin
                w_cls.sym_kind = K_INVALID;
                w_cls.symbol   = 1'b0;
            end
        endcase
    end

    assign o_stall             = i_full;
    assign o_push              = i_valid && !i_full;
    assign o_item.char_byte    = i_char_byte;
    assign o_item.end_of_input = i_end_of_input;
    assign o_item.cls          = w_cls;

endmodule

FILE: sv/stl_queue.sv
// Short FIFO of classified items between the front and back ends.
module stl_queue
    import stl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item           r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wp;
    logic [PW-1:0]   n_rp;

    assign n_wp    = (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp    = (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: sv/stl_back.sv
// Scanner engine: runs the lexer modes, sequences up to three tokens per item, output register.
module stl_back
    import stl_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_item             i_item,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_token_kind,
    output logic [CHAR_W-1:0] o_first_char,
    output logic [OFF_W-1:0]  o_start_offset,
    output logic [LEN_W-1:0]  o_token_length,
    output logic [LINE_W-1:0] o_line_number,
    output logic [COL_W-1:0]  o_column_number,
    output logic              o_last_of_run
);

    typedef enum logic [5:0] {
        M_IDLE    = 6'b000001,
        M_IDENT   = 6'b000010,
        M_INT     = 6'b000100,
        M_DOT     = 6'b001000,
        M_FRAC    = 6'b010000,
        M_COMMENT = 6'b100000
    } t_mode;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
    localparam logic [LEN_W-1:0]       LEN_MAX  = {LEN_W{1'b1}};

    localparam int OFF_XW  = (OFFSET_BITS > OFF_W) ? OFFSET_BITS : OFF_W;
    localparam int LINE_XW = (LINE_BITS > LINE_W) ? LINE_BITS : LINE_W;
    localparam int COL_XW  = (COLUMN_BITS > COL_W) ? COLUMN_BITS : COL_W;

    // scanner state
    t_mode                   r_mode;
    logic [OFFSET_BITS-1:0]  r_off;
    logic [LINE_BITS-1:0]    r_line;
    logic [COLUMN_BITS-1:0]  r_col;
    logic [OFFSET_BITS-1:0]  r_tok_off;
    logic [COLUMN_BITS-1:0]  r_tok_col;
    logic [LEN_W-1:0]        r_tok_len;
    logic [CHAR_W-1:0]       r_tok_first;
    logic                    r_eof;
    logic [1:0]              r_sub;
    logic                    r_ovalid;

    t_mode                   n_mode;
    logic [OFFSET_BITS-1:0]  n_tok_off;
    logic [COLUMN_BITS-1:0]  n_tok_col;
    logic [LEN_W-1:0]        n_tok_len;
    logic [CHAR_W-1:0]       n_tok_first;

    logic [OFFSET_BITS-1:0]  w_off_inc;
    logic [OFFSET_BITS-1:0]  w_off_dec;
    logic [LINE_BITS-1:0]    w_line_inc;
    logic [COLUMN_BITS-1:0]  w_col_inc;
    logic [COLUMN_BITS-1:0]  w_col_dec;
    logic [LEN_W-1:0]        w_len_inc;
    logic [LEN_W-1:0]        w_len_inc2;

    logic                    w_consumed;
    logic                    w_flush;
    logic                    w_has_a;
    logic                    w_has_b;
    logic                    w_emit_c;
    logic [1:0]              w_ntok;
    t_kind                   w_a_kind;
    t_kind                   w_c_kind;
    logic [CHAR_W-1:0]       w_c_first;
    logic [LEN_W-1:0]        w_c_len;
    logic [LINE_BITS-1:0]    w_c_line;
    logic [COLUMN_BITS-1:0]  w_c_col;

    logic                    w_sel_a;
    logic                    w_sel_b;
    t_kind                   w_s_kind;
    logic [CHAR_W-1:0]       w_s_first;
    logic [OFFSET_BITS-1:0]  w_s_off;
    logic [LEN_W-1:0]        w_s_len;
    logic [LINE_BITS-1:0]    w_s_line;
    logic [COLUMN_BITS-1:0]  w_s_col;
    logic [OFF_XW-1:0]       w_off_x;
    logic [LINE_XW-1:0]      w_line_x;
    logic [COL_XW-1:0]       w_col_x;

    logic                    w_fire;
    logic                    w_last;
    logic                    w_load;

    assign w_off_inc  = (r_off == OFF_MAX) ? r_off : r_off + 1'b1;
    assign w_off_dec  = (r_off == '0) ? r_off : r_off - 1'b1;
    assign w_line_inc = (r_line == LINE_MAX) ? r_line : r_line + 1'b1;
    assign w_col_inc  = (r_col == COL_MAX) ? r_col : r_col + 1'b1;
    assign w_col_dec  = (r_col == '0) ? r_col : r_col - 1'b1;
    assign w_len_inc  = (r_tok_len == LEN_MAX) ? r_tok_len : r_tok_len + 1'b1;
    assign w_len_inc2 = (r_tok_len >= LEN_MAX - 1'b1) ? LEN_MAX : r_tok_len + LEN_W'(2);

    always_comb begin
        n_mode      = r_mode;
        n_tok_off   = r_tok_off;
        n_tok_col   = r_tok_col;
        n_tok_len   = r_tok_len;
        n_tok_first = r_tok_first;
        w_consumed  = 1'b0;
        w_flush     = 1'b0;
        w_emit_c    = 1'b0;
        w_c_kind    = K_INVALID;
        w_c_first   = i_item.char_byte;
        w_c_len     = LEN_W'(1);
        w_c_line    = r_line;
        w_c_col     = r_col;
        if (i_item.end_of_input) begin
            w_flush   = 1'b1;
            w_emit_c  = 1'b1;
            w_c_kind  = K_EOF;
            w_c_first = CH_NUL;
            w_c_len   = '0;
            n_mode    = M_IDLE;
        end else begin
            case (r_mode)
                M_IDENT: begin
                    if (i_item.cls.word) begin
                        w_consumed = 1'b1;
                        n_tok_len  = w_len_inc;
                    end
                end
                M_INT: begin
                    if (i_item.cls.dot) begin
                        w_consumed = 1'b1;
                        n_mode     = M_DOT;
                    end else if (i_item.cls.digit) begin
                        w_consumed = 1'b1;
                        n_tok_len  = w_len_inc;
                    end
                end
                M_DOT: begin
                    if (i_item.cls.digit) begin
                        w_consumed = 1'b1;
                        n_mode     = M_FRAC;
                        n_tok_len  = w_len_inc2;
                    end
                end
                M_FRAC: begin
                    if (i_item.cls.digit) begin
                        w_consumed = 1'b1;
                        n_tok_len  = w_len_inc;
                    end
                end
                M_COMMENT: begin
                    w_consumed = !i_item.cls.newline;
                end
                default: begin
                    w_consumed = 1'b0;
                end
            endcase
            if (!w_consumed) begin
                w_flush = 1'b1;
                n_mode  = M_IDLE;
                if (i_item.cls.hash) begin
                    n_mode = M_COMMENT;
                end else if (i_item.cls.word) begin
                    n_mode      = i_item.cls.digit ? M_INT : M_IDENT;
                    n_tok_off   = r_off;
                    n_tok_col   = r_col;
                    n_tok_len   = LEN_W'(1);
                    n_tok_first = i_item.char_byte;
                end else if (i_item.cls.newline) begin
                    w_emit_c = 1'b1;
                    w_c_kind = K_EOL;
                    w_c_line = w_line_inc;
                    w_c_col  = '0;
                end else if (i_item.cls.symbol) begin
                    w_emit_c = 1'b1;
                    w_c_kind = i_item.cls.sym_kind;
                end else if (!i_item.cls.blank) begin
                    w_emit_c = 1'b1;
                    w_c_kind = K_INVALID;
                    w_c_col  = w_col_inc;
                end
            end
        end
    end

    // pending token first, then the period of a trailing dot, then this byte's own token
    assign w_has_a  = w_flush && ((r_mode == M_IDENT) || (r_mode == M_INT) ||
                                  (r_mode == M_DOT) || (r_mode == M_FRAC));
    assign w_has_b  = w_flush && (r_mode == M_DOT);
    assign w_a_kind = (r_mode == M_IDENT) ? K_IDENT : K_NUMBER;
    assign w_ntok   = r_eof ? 2'd0 : (2'(w_has_a) + 2'(w_has_b) + 2'(w_emit_c));

    assign w_sel_a = (r_sub == 2'd0) && w_has_a;
    assign w_sel_b = (r_sub == 2'd1) && w_has_b;

    assign w_s_kind  = w_sel_a ? w_a_kind    : (w_sel_b ? K_PERIOD   : w_c_kind);
    assign w_s_first = w_sel_a ? r_tok_first : (w_sel_b ? CH_DOT     : w_c_first);
    assign w_s_off   = w_sel_a ? r_tok_off   : (w_sel_b ? w_off_dec  : r_off);
    assign w_s_len   = w_sel_a ? r_tok_len   : (w_sel_b ? LEN_W'(1)  : w_c_len);
    assign w_s_line  = (w_sel_a || w_sel_b) ? r_line : w_c_line;
    assign w_s_col   = w_sel_a ? r_tok_col   : (w_sel_b ? w_col_dec  : w_c_col);

    assign w_off_x  = OFF_XW'(w_s_off);
    assign w_line_x = LINE_XW'(w_s_line);
    assign w_col_x  = COL_XW'(w_s_col);

    assign w_fire = !i_empty && (!r_ovalid || !i_stall);
    assign w_last = (2'(r_sub + 2'd1) == w_ntok);
    assign w_load = w_fire && (w_ntok != 2'd0);
    assign o_pop  = w_fire && ((w_ntok == 2'd0) || w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_off       <= '0;
            r_line      <= LINE_BITS'(1);
            r_col       <= COLUMN_BITS'(1);
            r_tok_off   <= '0;
            r_tok_col   <= '0;
            r_tok_len   <= '0;
            r_tok_first <= '0;
            r_eof       <= 1'b0;
            r_sub       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
                r_sub    <= w_last ? 2'd0 : r_sub + 2'd1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (o_pop && !r_eof) begin
                r_mode      <= n_mode;
                r_tok_off   <= n_tok_off;
                r_tok_col   <= n_tok_col;
                r_tok_len   <= n_tok_len;
                r_tok_first <= n_tok_first;
                if (i_item.end_of_input) begin
                    r_eof <= 1'b1;
                end else begin
                    r_off <= w_off_inc;
                    if (i_item.cls.newline) begin
                        r_line <= w_line_inc;
                        r_col  <= COLUMN_BITS'(1);
                    end else begin
                        r_col  <= w_col_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_token_kind    <= w_s_kind;
            o_first_char    <= w_s_first;
            o_start_offset  <= w_off_x[OFF_W-1:0];
            o_token_length  <= w_s_len;
            o_line_number   <= w_line_x[LINE_W-1:0];
            o_column_number <= w_col_x[COL_W-1:0];
            o_last_of_run   <= w_last;
        end
    end

    assign o_valid = r_ovalid;

endmodule
